@@ src/sed_pkg.sv @@
// shared types and constants for the rgb sobel edge detector
package sed_pkg;

	// configuration register map
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam int FW_BITS = 11;
	localparam int FH_BITS = 13;
	localparam int CFG_W   = 13;

	// packed pixel: red [23:16], green [15:8], blue [7:0]
	typedef logic [23:0] sed_pix_t;

	// 3x3 window, index = row * 3 + column, column 2 is the newest
	typedef sed_pix_t [8:0] sed_win_t;

	typedef struct packed {
		logic end_of_row;
		logic end_of_frame;
	} sed_flags_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		sed_flags_t flags;
	} sed_result_t;

endpackage

@@ src/sed_mag.sv @@
// gradient magnitude unit: sobel sums, squares and a rounded square root
module sed_mag (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  ready,
	input  sed_pkg::sed_win_t     taps,
	input  sed_pkg::sed_flags_t   flags,
	output logic                  done,
	input  logic                  take,
	output sed_pkg::sed_result_t  result
);
	import sed_pkg::*;

	localparam logic [2:0] M_IDLE = 3'd0;
	localparam logic [2:0] M_GRAD = 3'd1;
	localparam logic [2:0] M_SQ   = 3'd2;
	localparam logic [2:0] M_ROOT = 3'd3;
	localparam logic [2:0] M_HOLD = 3'd4;

	localparam int NCH = 3;
	localparam logic [20:0] SAT_LIMIT = 21'd65025;

	typedef struct packed {
		logic [9:0]  rem;
		logic [7:0]  root;
		logic [15:0] rad;
	} root_acc_t;

	function automatic logic [7:0] chan(sed_pix_t p, int k);
		return p[8*k +: 8];
	endfunction

	// a + 2b + c, at most 1020
	function automatic logic [10:0] wsum(logic [7:0] a, logic [7:0] b, logic [7:0] c);
		return {3'b000, a} + {2'b00, b, 1'b0} + {3'b000, c};
	endfunction

	function automatic logic [9:0] absdiff(logic [10:0] p, logic [10:0] n);
		logic [10:0] d;
		d = (p >= n) ? (p - n) : (n - p);
		return d[9:0];
	endfunction

	// four digits of the restoring square root
	function automatic root_acc_t root_steps(root_acc_t a);
		root_acc_t   x;
		logic [11:0] r;
		logic [11:0] trial;
		x = a;
		for (int i = 0; i < 4; i++) begin
			r     = {x.rem, x.rad[15:14]};
			trial = {2'b00, x.root, 2'b01};
			x.rad = {x.rad[13:0], 2'b00};
			if (r >= trial) begin
				r      = r - trial;
				x.root = {x.root[6:0], 1'b1};
			end else begin
				x.root = {x.root[6:0], 1'b0};
			end
			x.rem = r[9:0];
		end
		return x;
	endfunction

	logic [2:0]  state_q;
	logic        ph_q;
	sed_win_t    taps_q;
	sed_flags_t  flags_q;
	logic [9:0]  ax_q [NCH];
	logic [9:0]  ay_q [NCH];
	logic [NCH-1:0] sat_q;
	root_acc_t   acc_q [NCH];

	logic [9:0]  gx_abs [NCH];
	logic [9:0]  gy_abs [NCH];
	logic [19:0] sqx [NCH];
	logic [19:0] sqy [NCH];
	logic [20:0] sum_sq [NCH];
	logic [7:0]  rounded [NCH];

	always_comb begin
		for (int k = 0; k < NCH; k++) begin
			gx_abs[k] = absdiff(
				wsum(chan(taps_q[2], k), chan(taps_q[5], k), chan(taps_q[8], k)),
				wsum(chan(taps_q[0], k), chan(taps_q[3], k), chan(taps_q[6], k)));
			gy_abs[k] = absdiff(
				wsum(chan(taps_q[6], k), chan(taps_q[7], k), chan(taps_q[8], k)),
				wsum(chan(taps_q[0], k), chan(taps_q[1], k), chan(taps_q[2], k)));
			sqx[k]    = ax_q[k] * ax_q[k];
			sqy[k]    = ay_q[k] * ay_q[k];
			sum_sq[k] = {1'b0, sqx[k]} + {1'b0, sqy[k]};
			// remainder above the floor root means the true root is past the half point
			rounded[k] = sat_q[k] ? 8'd255
				: acc_q[k].root + 8'(acc_q[k].rem > {2'b00, acc_q[k].root});
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == M_IDLE && start) begin
			taps_q  <= taps;
			flags_q <= flags;
		end
		for (int k = 0; k < NCH; k++) begin
			if (state_q == M_GRAD) begin
				ax_q[k] <= gx_abs[k];
				ay_q[k] <= gy_abs[k];
			end
			if (state_q == M_SQ) begin
				sat_q[k]      <= (sum_sq[k] >= SAT_LIMIT);
				acc_q[k].rem  <= '0;
				acc_q[k].root <= '0;
				acc_q[k].rad  <= sum_sq[k][15:0];
			end
			if (state_q == M_ROOT) begin
				acc_q[k] <= root_steps(acc_q[k]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			ph_q    <= 1'b0;
		end else begin
			case (state_q)
				M_IDLE: begin
					if (start) state_q <= M_GRAD;
				end
				M_GRAD: state_q <= M_SQ;
				M_SQ: begin
					state_q <= M_ROOT;
					ph_q    <= 1'b0;
				end
				M_ROOT: begin
					ph_q <= ~ph_q;
					if (ph_q) state_q <= M_HOLD;
				end
				M_HOLD: begin
					if (take) state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign ready        = (state_q == M_IDLE);
	assign done         = (state_q == M_HOLD);
	assign result.red   = rounded[2];
	assign result.green = rounded[1];
	assign result.blue  = rounded[0];
	assign result.flags = flags_q;

endmodule

@@ src/sobel_edge_rgb.sv @@
// 3x3 sobel edge detector on an rgb pixel stream, top level
//
// pixels enter on the s_ side in raster order, one request per pixel; s_tuser
// marks a flush request that only advances the position. after the frame's
// width * height pixels, width + 1 flush requests drain the last results.
// results leave on the m_ side; the result for pixel (r, c) is produced by the
// request for position (r + 1, c + 1), wrapping through the row end.
// frame_width and frame_height are written through cfg_write / cfg_index /
// cfg_data; the user must write them only while the block is idle, which the
// block does not enforce. a write restarts the frame at (0, 0). a request is
// accepted in idle and passes the window state; one that yields a result waits
// in the issue state until the magnitude unit is ready, which takes one window
// through capture, sums, squares, root and handoff and no new one until its
// result is taken. the line memory is read in the accept cycle and written back
// the cycle after, so each request does one read-modify-write of its column
// entry. a result sits in the output register until m_tready; meanwhile
// requests are still taken until one that yields a result finds the magnitude
// unit busy. reset restores 640 x 480, position (0, 0) and a zero window; the
// line memory needs no clearing since rows outside the frame are masked.
module sobel_edge_rgb #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [23:0]               s_tdata,   // in_red, in_green, in_blue
	input  logic                      s_tuser,   // flush
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [23:0]               m_tdata,   // edge_red, edge_green, edge_blue
	output logic                      m_tlast,   // end_of_row
	output logic                      m_tuser,   // end_of_frame
	input  logic                      cfg_write,
	input  logic                      cfg_index,
	input  logic [sed_pkg::CFG_W-1:0] cfg_data
);
	import sed_pkg::*;

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int RW    = $clog2(MAX_HEIGHT + 2);
	localparam int WX    = (WW > FW_BITS) ? WW : FW_BITS;
	localparam int HX    = (HW > FH_BITS) ? HW : FH_BITS;
	localparam int W_RST = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
	localparam int H_RST = (MAX_HEIGHT < 480) ? MAX_HEIGHT : 480;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WIN   = 2'd1;
	localparam logic [1:0] ST_ISSUE = 2'd2;

	logic [1:0]    state_q;
	logic [WW-1:0] w_q;
	logic [HW-1:0] h_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	sed_win_t      win_q;

	// per request, captured at accept
	logic [CW-1:0] col_s1;
	sed_pix_t      pix_s1;
	logic          top_ok_s1;
	logic          mid_ok_s1;
	logic          wrap_s1;
	logic          mid_emit_s1;
	logic          left_s1;
	logic          eof_s1;
	logic [47:0]   rd_q;

	sed_win_t      taps_s2;
	sed_flags_t    flags_s2;

	// entry per column: {row two above, row above}
	logic [47:0]   line_mem [MAX_WIDTH];

	logic          mag_ready;
	logic          mag_done;
	sed_result_t   mag_result;
	logic          res_valid_q;
	sed_result_t   res_q;
	logic          load;

	logic [WX-1:0] fw_ext;
	logic [HX-1:0] fh_ext;
	logic [WW-1:0] w_new;
	logic [HW-1:0] h_new;

	logic          accept;
	logic [RW-1:0] h_r;
	logic          in_frame;
	logic          top_ok;
	logic          mid_ok;
	logic          at_col0;
	logic          wrap;
	logic          frame_done;
	logic [WW-1:0] col_inc;
	logic          row_end;
	sed_pix_t      in_pix;

	sed_pix_t      top_px;
	sed_pix_t      mid_px;
	sed_win_t      win_next;
	sed_win_t      snap;

	// register writes clamp into the supported range
	always_comb begin
		fw_ext = WX'(cfg_data[FW_BITS-1:0]);
		fh_ext = HX'(cfg_data[FH_BITS-1:0]);
		if (fw_ext == '0) begin
			w_new = WW'(1);
		end else if (fw_ext > WX'(MAX_WIDTH)) begin
			w_new = WW'(MAX_WIDTH);
		end else begin
			w_new = WW'(fw_ext);
		end
		if (fh_ext == '0) begin
			h_new = HW'(1);
		end else if (fh_ext > HX'(MAX_HEIGHT)) begin
			h_new = HW'(MAX_HEIGHT);
		end else begin
			h_new = HW'(fh_ext);
		end
	end

	always_comb begin
		accept     = s_tvalid && s_tready;
		h_r        = RW'(h_q);
		in_frame   = (row_q < h_r);
		top_ok     = (row_q >= RW'(2)) && ((row_q - RW'(2)) < h_r);
		mid_ok     = (row_q >= RW'(1)) && ((row_q - RW'(1)) < h_r);
		at_col0    = (col_q == '0);
		// column zero finishes the last column of the row two above
		wrap       = at_col0 && top_ok;
		frame_done = wrap && (row_q == h_r + RW'(1));
		col_inc    = WW'(col_q) + WW'(1);
		row_end    = (col_inc >= w_q);
		in_pix     = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
	end

	always_comb begin
		top_px = top_ok_s1 ? rd_q[47:24] : '0;
		mid_px = mid_ok_s1 ? rd_q[23:0] : '0;
		for (int i = 0; i < 3; i++) begin
			win_next[i*3]     = win_q[i*3+1];
			win_next[i*3 + 1] = win_q[i*3+2];
		end
		win_next[2] = top_px;
		win_next[5] = mid_px;
		win_next[8] = pix_s1;
		snap = win_next;
		if (wrap_s1) begin
			snap[2] = '0;
			snap[5] = '0;
			snap[8] = '0;
		end
		if (left_s1) begin
			snap[0] = '0;
			snap[3] = '0;
			snap[6] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			w_q     <= WW'(W_RST);
			h_q     <= HW'(H_RST);
			col_q   <= '0;
			row_q   <= '0;
			win_q   <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_FRAME_WIDTH:  w_q <= w_new;
					REG_FRAME_HEIGHT: h_q <= h_new;
					default: ;
				endcase
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				if (frame_done) begin
					col_q <= '0;
					row_q <= '0;
				end else if (row_end) begin
					col_q <= '0;
					row_q <= row_q + RW'(1);
				end else begin
					col_q <= col_inc[CW-1:0];
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_WIN;
				end
				ST_WIN: begin
					win_q   <= win_next;
					state_q <= (wrap_s1 || mid_emit_s1) ? ST_ISSUE : ST_IDLE;
				end
				ST_ISSUE: begin
					if (mag_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1      <= col_q;
			pix_s1      <= (!s_tuser && in_frame) ? in_pix : '0;
			top_ok_s1   <= top_ok;
			mid_ok_s1   <= mid_ok;
			wrap_s1     <= wrap;
			mid_emit_s1 <= !at_col0 && mid_ok;
			left_s1     <= (col_q == CW'(1)) || (w_q == WW'(1));
			eof_s1      <= frame_done;
		end
		if (state_q == ST_WIN) begin
			taps_s2                <= snap;
			flags_s2.end_of_row    <= wrap_s1;
			flags_s2.end_of_frame  <= eof_s1;
		end
	end

	// line memory: read at accept, write back the shifted rows in the next cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= line_mem[col_q];
		end
		if (state_q == ST_WIN) begin
			line_mem[col_s1] <= {rd_q[23:0], pix_s1};
		end
	end

	sed_mag u_mag (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_ISSUE),
		.ready  (mag_ready),
		.taps   (taps_s2),
		.flags  (flags_s2),
		.done   (mag_done),
		.take   (load),
		.result (mag_result)
	);

	assign load = mag_done && (!res_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) res_q <= mag_result;
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = res_valid_q;
	assign m_tdata  = {res_q.blue, res_q.green, res_q.red};
	assign m_tlast  = res_q.flags.end_of_row;
	assign m_tuser  = res_q.flags.end_of_frame;

endmodule

@@ tb/sobel_edge_rgb_tb.sv @@
// self-checking testbench for the rgb sobel edge detector
module sobel_edge_rgb_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sed_pkg::*;

	localparam int MAX_W       = 1024;
	localparam int MAX_H       = 4096;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE      = 20;
	localparam int RANDOM_REQS = 460;

	// predicts the edge magnitudes and compares them with what leaves the block
	class edge_scoreboard;
		logic [FW_BITS-1:0] width_reg;
		logic [FH_BITS-1:0] height_reg;
		sed_pix_t           line_mem [2*MAX_W];
		sed_win_t           taps;
		int unsigned        col;
		int unsigned        row;
		sed_result_t        edge_q [$];
		int                 errors;
		int                 seen;
		int                 requests;

		function new();
			width_reg  = 640;
			height_reg = 480;
			foreach (line_mem[i])
				line_mem[i] = '0;
			taps     = '0;
			col      = 0;
			row      = 0;
			errors   = 0;
			seen     = 0;
			requests = 0;
		endfunction

		function void set_reg(logic idx, logic [CFG_W-1:0] val);
			if (idx == REG_FRAME_WIDTH)
				width_reg = val[FW_BITS-1:0];
			else
				height_reg = val[FH_BITS-1:0];
			col = 0;
			row = 0;
		endfunction

		function int chan(sed_pix_t p, int sh);
			return int'(p[sh +: 8]);
		endfunction

		function logic [7:0] grad_mag(sed_win_t t, int sh);
			int gx;
			int gy;
			int s;
			int f;
			gx = (chan(t[2], sh) + 2 * chan(t[5], sh) + chan(t[8], sh))
			   - (chan(t[0], sh) + 2 * chan(t[3], sh) + chan(t[6], sh));
			gy = (chan(t[6], sh) + 2 * chan(t[7], sh) + chan(t[8], sh))
			   - (chan(t[0], sh) + 2 * chan(t[1], sh) + chan(t[2], sh));
			s = gx * gx + gy * gy;
			if (s >= 65025)
				return 8'd255;
			f = 0;
			for (int b = 128; b != 0; b = b >> 1) begin
				if ((f | b) * (f | b) <= s)
					f = f | b;
			end
			// round to nearest
			if (s > f * f + f)
				f++;
			return f[7:0];
		endfunction

		// word is in port order: red lowest
		function void note_request(logic [23:0] word, logic fl);
			int unsigned w;
			int unsigned h;
			int unsigned r;
			int unsigned c;
			int unsigned res_r;
			int unsigned res_c;
			sed_pix_t    pix;
			sed_pix_t    top;
			sed_pix_t    mid;
			sed_win_t    t;
			bit          emit;
			sed_result_t res;
			w = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
			h = (height_reg == 0) ? 1 : ((height_reg > MAX_H) ? MAX_H : height_reg);
			requests++;
			if (col >= w || row > h + 1) begin
				col = 0;
				row = 0;
			end
			r = row;
			c = col;
			pix = (!fl && r < h) ? {word[7:0], word[15:8], word[23:16]} : '0;
			top = (r >= 2 && r - 2 < h) ? line_mem[c] : '0;
			mid = (r >= 1 && r - 1 < h) ? line_mem[MAX_W + c] : '0;
			line_mem[c] = line_mem[MAX_W + c];
			line_mem[MAX_W + c] = pix;
			emit = 1'b0;
			t = '0;
			res_r = 0;
			res_c = 0;
			// last column of row r-2 comes out of the window before it shifts
			if (c == 0 && r >= 2 && r - 2 < h) begin
				emit = 1'b1;
				res_r = r - 2;
				res_c = w - 1;
				for (int i = 0; i < 3; i++) begin
					t[i*3]     = taps[i*3 + 1];
					t[i*3 + 1] = taps[i*3 + 2];
					t[i*3 + 2] = '0;
				end
			end
			for (int i = 0; i < 3; i++) begin
				taps[i*3]     = taps[i*3 + 1];
				taps[i*3 + 1] = taps[i*3 + 2];
			end
			taps[2] = top;
			taps[5] = mid;
			taps[8] = pix;
			if (c != 0 && r >= 1 && r - 1 < h) begin
				emit = 1'b1;
				res_r = r - 1;
				res_c = c - 1;
				t = taps;
			end
			c++;
			if (c >= w) begin
				c = 0;
				r++;
			end
			col = c;
			row = r;
			if (!emit)
				return;
			if (res_c == 0) begin
				t[0] = '0;
				t[3] = '0;
				t[6] = '0;
			end
			if (res_c == w - 1) begin
				t[2] = '0;
				t[5] = '0;
				t[8] = '0;
			end
			res.red                = grad_mag(t, 16);
			res.green              = grad_mag(t, 8);
			res.blue               = grad_mag(t, 0);
			res.flags.end_of_row   = (res_c == w - 1);
			res.flags.end_of_frame = (res_c == w - 1 && res_r == h - 1);
			if (res.flags.end_of_frame) begin
				col = 0;
				row = 0;
			end
			edge_q.push_back(res);
		endfunction

		function void report(string field, int want, int got);
			errors++;
			if (errors <= 40)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		endfunction

		function void check_result(sed_result_t got);
			sed_result_t want;
			seen++;
			if (edge_q.size() == 0) begin
				errors++;
				if (errors <= 40)
					$display("%0t: result with none expected, expected nothing, actual %p",
						$time, got);
				return;
			end
			want = edge_q.pop_front();
			if (got.red != want.red)
				report("edge_red", want.red, got.red);
			if (got.green != want.green)
				report("edge_green", want.green, got.green);
			if (got.blue != want.blue)
				report("edge_blue", want.blue, got.blue);
			if (got.flags.end_of_row != want.flags.end_of_row)
				report("end_of_row", want.flags.end_of_row, got.flags.end_of_row);
			if (got.flags.end_of_frame != want.flags.end_of_frame)
				report("end_of_frame", want.flags.end_of_frame, got.flags.end_of_frame);
		endfunction

		function int pending();
			return edge_q.size();
		endfunction
	endclass

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [23:0]       s_tdata   = '0;  // in_red, in_green, in_blue
	logic              s_tuser   = 1'b0; // flush
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [23:0]       m_tdata;         // edge_red, edge_green, edge_blue
	logic              m_tlast;         // end_of_row
	logic              m_tuser;         // end_of_frame
	logic              cfg_write = 1'b0;
	logic              cfg_index = 1'b0;
	logic [CFG_W-1:0]  cfg_data  = '0;

	edge_scoreboard sb = new();
	int             src_idle_pct  = 0;
	int             sink_idle_pct = 0;
	int             sent_count    = 0;
	int             cycle_count   = 0;

	sobel_edge_rgb #(
		.MAX_WIDTH  (MAX_W),
		.MAX_HEIGHT (MAX_H)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, sb.pending());
			$display("Mismatches found");
			$finish;
		end
	end

	// result monitor, values sampled as they stood at the edge
	always @(posedge clk) begin
		sed_result_t got;
		if (m_tvalid === 1'b1 && m_tready) begin
			got.red                = m_tdata[7:0];
			got.green              = m_tdata[15:8];
			got.blue               = m_tdata[23:16];
			got.flags.end_of_row   = m_tlast;
			got.flags.end_of_frame = m_tuser;
			sb.check_result(got);
		end
	end

	// receiver: random stalls plus one long hold-off so the input side backs up
	initial begin
		int hold_left;
		bit held;
		hold_left = 0;
		held      = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && sb.seen >= 60) begin
				held      = 1'b1;
				hold_left = 600;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	function automatic logic [23:0] rand_pix(int style);
		logic [23:0] v;
		v = 24'($urandom);
		for (int k = 0; k < 3; k++) begin
			if (style == 1)
				v[k*8 +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
			else if (style == 2)
				v[k*8 +: 8] = 8'(120 + $urandom_range(15));
		end
		return v;
	endfunction

	task automatic push_req(input logic [23:0] word, input logic fl);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		s_tuser  <= fl;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_request(word, fl);
		sent_count++;
	endtask

	// wait for every expected result, then give the block time to finish
	// any request that produces nothing
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic load_geometry(input logic [CFG_W-1:0] wv, input logic [CFG_W-1:0] hv);
		cfg_write <= 1'b1;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data  <= wv;
		@(posedge clk);
		sb.set_reg(REG_FRAME_WIDTH, wv);
		cfg_index <= REG_FRAME_HEIGHT;
		cfg_data  <= hv;
		@(posedge clk);
		sb.set_reg(REG_FRAME_HEIGHT, hv);
		cfg_write <= 1'b0;
		cfg_data  <= '0;
	endtask

	// pixels in raster order with the odd flush inside the frame, then the
	// drain run, part of it as ignored pixels past the frame end, unless cut
	task automatic send_frame(input int w, input int h, input int style, input bit cut);
		int total;
		total = w * h;
		if (cut)
			total = $urandom_range(total);
		for (int n = 0; n < total; n++)
			push_req(rand_pix(style), $urandom_range(29) == 0);
		if (!cut) begin
			for (int n = 0; n <= w; n++)
				push_req(rand_pix(style), $urandom_range(3) != 0);
		end
	endtask

	initial begin
		int          mark;
		int          done;
		int          w;
		int          h;
		int          frames;
		logic [CFG_W-1:0] wv;
		logic [CFG_W-1:0] hv;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct  = 17;
		sink_idle_pct = 48;

		// reset geometry is 640 x 480, a few pixels give no results yet
		repeat (3) push_req(rand_pix(0), 1'b0);
		settle();

		// 3x2 with extremes, a flush inside the frame and a pixel past the end
		load_geometry(13'd3, 13'd2);
		push_req(24'hFFFFFF, 1'b0);
		push_req(24'h000000, 1'b0);
		push_req(24'hFFFFFF, 1'b0);
		push_req(24'hFFFFFF, 1'b1);
		push_req(24'h00FF00, 1'b0);
		push_req(24'hFF00FF, 1'b0);
		push_req(24'h000000, 1'b1);
		push_req(24'hFFFFFF, 1'b0);
		push_req(24'h000000, 1'b1);
		push_req(24'h000000, 1'b1);
		settle();

		// zero values clamp to a single pixel frame
		load_geometry(13'd0, 13'd0);
		push_req(24'hFFFFFF, 1'b0);
		push_req(24'h000000, 1'b1);
		push_req(24'hFFFFFF, 1'b0);
		settle();

		// 2x3 checkerboard at full contrast, saturating magnitudes
		load_geometry(13'd2, 13'd3);
		push_req(24'hFFFFFF, 1'b0);
		push_req(24'h000000, 1'b0);
		push_req(24'h000000, 1'b0);
		push_req(24'hFFFFFF, 1'b0);
		push_req(24'hFFFFFF, 1'b0);
		push_req(24'h000000, 1'b0);
		repeat (3) push_req(24'h000000, 1'b1);
		settle();

		// random geometries and content
		mark = sent_count;
		while (sent_count - mark < RANDOM_REQS) begin
			done = sent_count - mark;
			if (done < RANDOM_REQS / 3) begin
				src_idle_pct  = 17;
				sink_idle_pct = 48;
			end else if (done < 2 * RANDOM_REQS / 3) begin
				src_idle_pct  = 48;
				sink_idle_pct = 17;
			end else begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			if ($urandom_range(9) == 0)
				wv = CFG_W'($urandom_range(9, 40));
			else
				wv = CFG_W'($urandom_range(1, 8));
			hv = CFG_W'($urandom_range(1, 6));
			if ($urandom_range(15) == 0)
				wv = '0;
			if ($urandom_range(15) == 0)
				hv = '0;
			w = (wv == '0) ? 1 : int'(wv);
			h = (hv == '0) ? 1 : int'(hv);
			load_geometry(wv, hv);
			frames = ($urandom_range(3) == 0) ? 2 : 1;
			for (int f = 0; f < frames; f++)
				send_frame(w, h, $urandom_range(2), f == frames - 1 && $urandom_range(7) == 0);
			settle();
		end

		// widest frame through a value that clamps, run into the second row so
		// the row break at the clamped width shows
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		load_geometry(13'h1FFF, 13'd1);
		for (int n = 0; n < MAX_W + 6; n++)
			push_req(rand_pix(0), n >= MAX_W);
		settle();
		// tallest frame through a value that clamps, first rows only
		load_geometry(13'd1, 13'h1FFF);
		for (int n = 0; n < 30; n++)
			push_req(rand_pix(1), 1'b0);
		settle();

		$display("ran %0d pixel and flush requests, %0d edge results checked",
			sb.requests, sb.seen);
		$display("full frames up to 40 wide, cut frames, and the first rows of clamped geometries");
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
